[design/psb_pkg.sv]
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types, register indexes and helpers for the padded sprite blit core.
// ----------------------------------------------------------------------------
package psb_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = 13;
	localparam int POS_W   = 12;
	localparam int COORD_W = 14;
	localparam int PITCH_W = 13;
	localparam int PROD_W  = COORD_W + PITCH_W;
	localparam int ADDR_W  = 24;
	localparam int PAD_W   = 2;
	localparam int NUM_SEG = 9;

	localparam logic [2:0] CFG_DEST_LEFT  = 3'd0;
	localparam logic [2:0] CFG_DEST_TOP   = 3'd1;
	localparam logic [2:0] CFG_WIDTH      = 3'd2;
	localparam logic [2:0] CFG_HEIGHT     = 3'd3;
	localparam logic [2:0] CFG_BORDER     = 3'd4;
	localparam logic [2:0] CFG_PITCH      = 3'd5;
	localparam logic [2:0] CFG_OVERLAY    = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		SEG_INT   = 4'd0,
		SEG_LEFT  = 4'd1,
		SEG_RIGHT = 4'd2,
		SEG_TOP   = 4'd3,
		SEG_BOT   = 4'd4,
		SEG_TL    = 4'd5,
		SEG_TR    = 4'd6,
		SEG_BL    = 4'd7,
		SEG_BR    = 4'd8
	} seg_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// floor(n/5) for n < 1280 by reciprocal multiply
	function automatic logic [7:0] div5(input logic [10:0] n);
		logic [21:0] prod;
		prod = 22'(n) * 22'd1639;
		return prod[20:13];
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		else
			return v;
	endfunction

endpackage

[design/padded_sprite_blit_core.sv]
// ----------------------------------------------------------------------------
// padded_sprite_blit_core
// Sprite blit into an atlas with a clamp-to-edge padding border.
// ----------------------------------------------------------------------------
// Source RGBA pixels enter in raster order on the s_axis channel, one beat per
// pixel. Each pixel yields a burst of atlas write beats on m_axis: the
// interior write first, then left, right, top and bottom border copies and the
// four corner squares as the pixel position calls for; tlast marks the final
// beat of the burst. Geometry and the overlay blend are set through the
// cfg_we / cfg_index / cfg_data port; the user must write them only while the
// block is idle, which the block does not enforce. Any valid write restarts the
// sprite at position (0,0). Every write beat passes through one shared
// multiplier (row times pitch) in ST_MUL, and the column add follows in
// ST_OUT, where the beat is loaded into the output register. A burst has one
// beat for an interior pixel and up to 49 for a corner pixel with a border
// of three; the next pixel is accepted only once the burst is complete.
// s_axis_tready is high only between bursts.
// Reset returns the registers to their defaults and the position to (0,0).
// While m_axis_tready is low the output register holds its beat and the
// sequencer waits.
// ----------------------------------------------------------------------------
module padded_sprite_blit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// src_red, src_green, src_blue, src_alpha
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// write_address, out_red, out_green, out_blue, out_alpha
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int DW = psb_pkg::DIM_W;
	localparam int PW = psb_pkg::POS_W;
	localparam int CW = psb_pkg::COORD_W;
	localparam int NS = psb_pkg::NUM_SEG;

	logic [PW-1:0]                   dest_left_q;
	logic [PW-1:0]                   dest_top_q;
	logic [DW-1:0]                   width_q;
	logic [DW-1:0]                   height_q;
	logic [psb_pkg::PAD_W-1:0]       pad_q;
	logic [psb_pkg::PITCH_W-1:0]     pitch_q;
	logic                            overlay_q;

	logic [PW-1:0]                   col_cnt_q;
	logic [PW-1:0]                   row_cnt_q;

	psb_pkg::state_t                 state_q, state_d;
	psb_pkg::seg_t                   seg_q, seg_d;
	logic [psb_pkg::PAD_W-1:0]       i_q, i_d, j_q, j_d;
	logic [NS-1:0]                   en_q;
	logic [CW-1:0]                   rowa_q, rowc_q, cold_q, colf_q;
	psb_pkg::pixel_t                 pix_q, blend_q;
	logic [psb_pkg::PROD_W-1:0]      prod_q;
	logic [CW-1:0]                   colsel_q;

	logic                            m_valid_q;
	logic [55:0]                     m_data_q;
	logic                            m_last_q;

	logic [DW-1:0]                   w_eff, h_eff;
	logic [DW-1:0]                   pt, pl;
	logic                            first_col, last_col, first_row, last_row;
	logic                            in_fire, load;
	logic [CW-1:0]                   row_sel, col_sel;
	logic                            seg_end, found, last;
	psb_pkg::seg_t                   seg_nxt;
	psb_pkg::pixel_t                 src_px, blend_px, out_px;
	logic [psb_pkg::ADDR_W-1:0]      addr;
	logic [PW:0]                     col_inc;

	assign w_eff     = psb_pkg::clamp_dim(width_q);
	assign h_eff     = psb_pkg::clamp_dim(height_q);
	assign pt        = DW'(dest_top_q) + DW'(pad_q);
	assign pl        = DW'(dest_left_q) + DW'(pad_q);
	assign first_col = (col_cnt_q == '0);
	assign last_col  = (DW'(col_cnt_q) == w_eff - DW'(1));
	assign first_row = (row_cnt_q == '0);
	assign last_row  = (DW'(row_cnt_q) == h_eff - DW'(1));
	assign col_inc   = {1'b0, col_cnt_q} + (PW+1)'(1);

	assign s_axis_tready = (state_q == psb_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign load          = !m_valid_q || m_axis_tready;

	assign src_px = psb_pkg::pixel_t'(s_axis_tdata);

	always_comb begin
		if (overlay_q) begin
			blend_px.red   = psb_pkg::div5({2'b00, src_px.red, 1'b0});
			blend_px.green = psb_pkg::div5({2'b00, src_px.green, 1'b0} + 11'd765);
			blend_px.blue  = psb_pkg::div5({2'b00, src_px.blue, 1'b0});
			blend_px.alpha = psb_pkg::div5({2'b00, src_px.alpha, 1'b0} + 11'd765);
		end else begin
			blend_px = src_px;
		end
	end

	always_comb begin
		row_sel = rowa_q;
		col_sel = cold_q;
		unique case (seg_q)
			psb_pkg::SEG_INT: begin
				row_sel = rowa_q;
				col_sel = cold_q;
			end
			psb_pkg::SEG_LEFT: begin
				row_sel = rowa_q;
				col_sel = CW'(dest_left_q) + CW'(i_q);
			end
			psb_pkg::SEG_RIGHT: begin
				row_sel = rowa_q;
				col_sel = colf_q + CW'(i_q);
			end
			psb_pkg::SEG_TOP: begin
				row_sel = CW'(dest_top_q) + CW'(i_q);
				col_sel = cold_q;
			end
			psb_pkg::SEG_BOT: begin
				row_sel = rowc_q + CW'(i_q);
				col_sel = cold_q;
			end
			psb_pkg::SEG_TL: begin
				row_sel = CW'(dest_top_q) + CW'(i_q);
				col_sel = CW'(dest_left_q) + CW'(j_q);
			end
			psb_pkg::SEG_TR: begin
				row_sel = CW'(dest_top_q) + CW'(i_q);
				col_sel = colf_q + CW'(j_q);
			end
			psb_pkg::SEG_BL: begin
				row_sel = rowc_q + CW'(i_q);
				col_sel = CW'(dest_left_q) + CW'(j_q);
			end
			psb_pkg::SEG_BR: begin
				row_sel = rowc_q + CW'(i_q);
				col_sel = colf_q + CW'(j_q);
			end
			default: begin
				row_sel = rowa_q;
				col_sel = cold_q;
			end
		endcase
	end

	always_comb begin
		found   = 1'b0;
		seg_nxt = psb_pkg::SEG_INT;
		for (int k = 0; k < NS; k++) begin
			if (!found && en_q[k] && (4'(k) > seg_q)) begin
				found   = 1'b1;
				seg_nxt = psb_pkg::seg_t'(4'(k));
			end
		end
	end

	always_comb begin
		if (seg_q == psb_pkg::SEG_INT)
			seg_end = 1'b1;
		else if (seg_q >= psb_pkg::SEG_TL)
			seg_end = (i_q == pad_q - 2'd1) && (j_q == pad_q - 2'd1);
		else
			seg_end = (i_q == pad_q - 2'd1);
	end

	assign last   = seg_end && !found;
	assign out_px = (seg_q == psb_pkg::SEG_INT) ? blend_q : pix_q;
	assign addr   = psb_pkg::ADDR_W'(prod_q + psb_pkg::PROD_W'(colsel_q));

	always_comb begin
		state_d = state_q;
		seg_d   = seg_q;
		i_d     = i_q;
		j_d     = j_q;
		unique case (state_q)
			psb_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = psb_pkg::ST_MUL;
					seg_d   = psb_pkg::SEG_INT;
					i_d     = '0;
					j_d     = '0;
				end
			end
			psb_pkg::ST_MUL: begin
				state_d = psb_pkg::ST_OUT;
			end
			psb_pkg::ST_OUT: begin
				if (load) begin
					if (last) begin
						state_d = psb_pkg::ST_IDLE;
					end else begin
						state_d = psb_pkg::ST_MUL;
						if (seg_end) begin
							seg_d = seg_nxt;
							i_d   = '0;
							j_d   = '0;
						end else if (seg_q >= psb_pkg::SEG_TL) begin
							if (j_q == pad_q - 2'd1) begin
								j_d = '0;
								i_d = i_q + 2'd1;
							end else begin
								j_d = j_q + 2'd1;
							end
						end else begin
							i_d = i_q + 2'd1;
						end
					end
				end
			end
			default: begin
				state_d = psb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psb_pkg::ST_IDLE;
			seg_q   <= psb_pkg::SEG_INT;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_left_q <= '0;
			dest_top_q  <= '0;
			width_q     <= DW'(1);
			height_q    <= DW'(1);
			pad_q       <= '0;
			pitch_q     <= psb_pkg::PITCH_W'(4096);
			overlay_q   <= 1'b0;
			col_cnt_q   <= '0;
			row_cnt_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psb_pkg::CFG_DEST_LEFT: dest_left_q <= cfg_data[PW-1:0];
				psb_pkg::CFG_DEST_TOP:  dest_top_q  <= cfg_data[PW-1:0];
				psb_pkg::CFG_WIDTH:     width_q     <= cfg_data;
				psb_pkg::CFG_HEIGHT:    height_q    <= cfg_data;
				psb_pkg::CFG_BORDER:    pad_q       <= cfg_data[psb_pkg::PAD_W-1:0];
				psb_pkg::CFG_PITCH:     pitch_q     <= cfg_data;
				psb_pkg::CFG_OVERLAY:   overlay_q   <= cfg_data[0];
				default: ;
			endcase
			if (cfg_index <= psb_pkg::CFG_OVERLAY) begin
				col_cnt_q <= '0;
				row_cnt_q <= '0;
			end
		end else if (in_fire) begin
			if (last_col) begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row ? '0 : row_cnt_q + PW'(1);
			end else begin
				col_cnt_q <= col_inc[PW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (in_fire) begin
			en_q[psb_pkg::SEG_INT]   <= 1'b1;
			en_q[psb_pkg::SEG_LEFT]  <= (pad_q != '0) && first_col;
			en_q[psb_pkg::SEG_RIGHT] <= (pad_q != '0) && last_col;
			en_q[psb_pkg::SEG_TOP]   <= (pad_q != '0) && first_row;
			en_q[psb_pkg::SEG_BOT]   <= (pad_q != '0) && last_row;
			en_q[psb_pkg::SEG_TL]    <= (pad_q != '0) && first_col && first_row;
			en_q[psb_pkg::SEG_TR]    <= (pad_q != '0) && last_col && first_row;
			en_q[psb_pkg::SEG_BL]    <= (pad_q != '0) && first_col && last_row;
			en_q[psb_pkg::SEG_BR]    <= (pad_q != '0) && last_col && last_row;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q   <= src_px;
			blend_q <= blend_px;
			rowa_q  <= CW'(pt) + CW'(row_cnt_q);
			rowc_q  <= CW'(pt) + CW'(h_eff);
			cold_q  <= CW'(pl) + CW'(col_cnt_q);
			colf_q  <= CW'(pl) + CW'(w_eff);
		end
		if (state_q == psb_pkg::ST_MUL) begin
			prod_q   <= psb_pkg::PROD_W'(row_sel) * psb_pkg::PROD_W'(pitch_q);
			colsel_q <= col_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else if (state_q == psb_pkg::ST_OUT && load) begin
			m_valid_q <= 1'b1;
			m_last_q  <= last;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == psb_pkg::ST_OUT && load)
			m_data_q <= {out_px.alpha, out_px.blue, out_px.green, out_px.red, addr};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_start_interior: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == psb_pkg::ST_MUL) && (seg_q == psb_pkg::SEG_INT))
		else $error("burst does not start with the interior write");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psb_pkg::ST_OUT) && load && last |=> (state_q == psb_pkg::ST_IDLE))
		else $error("sequencer busy after final beat");

	a_border_needs_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != psb_pkg::ST_IDLE) && (seg_q != psb_pkg::SEG_INT) |->
			(pad_q != '0) && (i_q < pad_q) && (j_q < pad_q))
		else $error("border index out of range");

	a_column_in_sprite: assert property (@(posedge clk) disable iff (!arst_n)
		(DW'(col_cnt_q) < w_eff) && (DW'(row_cnt_q) < h_eff))
		else $error("position outside sprite");
`endif

endmodule
